FILE: sv/srdb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHiP/RRIP dead-block replacement package
// Shared constants, row layouts, port structs and small helper functions.
// ----------------------------------------------------------------------------
package srdb_pkg;

  localparam int unsigned NumSets  = 2048;
  localparam int unsigned SetW     = 11;
  localparam int unsigned NumWays  = 16;
  localparam int unsigned WayW     = 4;
  localparam int unsigned PcW      = 22;
  localparam int unsigned SigW     = 6;
  localparam int unsigned PredRows = 128;
  localparam int unsigned PredRowW = 7;
  localparam int unsigned PredCols = 64;
  localparam int unsigned CntW     = 16;
  localparam int unsigned SweepW   = SetW + 1;
  localparam int unsigned EntryW   = SigW + 4;
  localparam int unsigned RowW     = NumWays * EntryW;
  localparam int unsigned PredW    = PredCols * 2;

  typedef logic [1:0] ctr2_t;

  localparam ctr2_t RrpvDistant = 2'd3;
  localparam ctr2_t RrpvLong    = 2'd2;
  localparam ctr2_t RrpvNear    = 2'd0;
  localparam ctr2_t CtrMax      = 2'd3;
  localparam ctr2_t DeadInit    = 2'd2;
  localparam ctr2_t PredInit    = 2'd1;
  localparam logic [CntW-1:0] DecayReset = 16'd4096;

  // One block's state; rrpv sits in the lowest bits.
  typedef struct packed {
    logic [SigW-1:0] sig;
    ctr2_t           dead;
    ctr2_t           rrpv;
  } entry_t;

  typedef entry_t [NumWays-1:0] row_t;
  typedef ctr2_t [PredCols-1:0] prow_t;

  typedef struct packed {
    logic [SetW-1:0] set;
    logic [SigW-1:0] sig;
    logic            hit;
    logic [WayW-1:0] way;
  } access_t;

  typedef struct packed {
    logic            dead;
    ctr2_t           rrpv;
    logic [WayW-1:0] way;
  } result_t;

  typedef struct packed {
    logic            we;
    logic [SetW-1:0] waddr;
    row_t            wdata;
    logic [SetW-1:0] raddr;
  } blk_port_t;

  typedef struct packed {
    logic                we;
    logic [PredRowW-1:0] waddr;
    prow_t               wdata;
    logic [PredRowW-1:0] raddr;
  } prd_port_t;

  typedef struct packed {
    logic init;
    logic sweep;
  } status_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SWEEP,
    ST_READ,
    ST_DATA,
    ST_WRITE
  } state_e;

  function automatic logic [SigW-1:0] make_sig(input logic [PcW-1:0] pc);
    make_sig = pc[5:0] ^ pc[13:8] ^ pc[21:16];
  endfunction

  function automatic row_t row_reset();
    row_t r;
    for (int w = 0; w < NumWays; w++) begin
      r[w].rrpv = RrpvDistant;
      r[w].dead = DeadInit;
      r[w].sig  = '0;
    end
    return r;
  endfunction

  function automatic prow_t prow_reset();
    prow_t p;
    for (int c = 0; c < PredCols; c++) begin
      p[c] = PredInit;
    end
    return p;
  endfunction

  // Saturating decrement of every dead counter in a row.
  function automatic row_t row_decay(input row_t r);
    row_t o;
    o = r;
    for (int w = 0; w < NumWays; w++) begin
      if (r[w].dead != 2'd0) begin
        o[w].dead = r[w].dead - 2'd1;
      end
    end
    return o;
  endfunction

endpackage

FILE: sv/srdb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module srdb_ram #(
  parameter int unsigned DataW = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataW-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataW-1:0]         rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/srdb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHiP/RRIP access sequencer
// Runs the init pass, the decay sweep and the read-modify-write of one set.
// ----------------------------------------------------------------------------
module srdb_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  srdb_pkg::access_t        in_data_i,
  input  logic [srdb_pkg::CntW-1:0] period_i,
  input  logic                     res_ready_i,
  output logic                     res_valid_o,
  output srdb_pkg::result_t        res_o,
  output srdb_pkg::blk_port_t      blk_o,
  input  srdb_pkg::row_t           blk_rdata_i,
  output srdb_pkg::prd_port_t      prd_o,
  input  srdb_pkg::prow_t          prd_rdata_i,
  output srdb_pkg::status_t        status_o
);
  import srdb_pkg::*;

  state_e            state_q, state_d;
  logic [SweepW-1:0] sw_q, sw_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  access_t           acc_q, acc_d;
  row_t              row_q, row_d;
  logic [WayW-1:0]   way_q, way_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      sw_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      sw_q    <= sw_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    row_q <= row_d;
    way_q <= way_d;
  end

  // Aging and victim search on the row just read.
  row_t            aged;
  logic [WayW-1:0] victim;
  logic            any3, any2, any1;
  ctr2_t           delta;

  always_comb begin
    any3 = 1'b0;
    any2 = 1'b0;
    any1 = 1'b0;
    for (int w = 0; w < NumWays; w++) begin
      any3 |= (blk_rdata_i[w].rrpv == 2'd3);
      any2 |= (blk_rdata_i[w].rrpv == 2'd2);
      any1 |= (blk_rdata_i[w].rrpv == 2'd1);
    end
    if (any3)      delta = 2'd0;
    else if (any2) delta = 2'd1;
    else if (any1) delta = 2'd2;
    else           delta = 2'd3;
    aged = blk_rdata_i;
    for (int w = 0; w < NumWays; w++) begin
      aged[w].rrpv = blk_rdata_i[w].rrpv + delta;
    end
    victim = '0;
    for (int w = NumWays - 1; w >= 0; w--) begin
      if (aged[w].rrpv == RrpvDistant) begin
        victim = WayW'(w);
      end
    end
  end

  // Update of the chosen block and its predictor row.
  entry_t  old_e, new_e;
  prow_t   prow_n;
  ctr2_t   dead_dec, pnew;
  result_t res;

  always_comb begin
    old_e    = row_q[way_q];
    prow_n   = prd_rdata_i;
    new_e    = old_e;
    dead_dec = (old_e.dead != 2'd0) ? old_e.dead - 2'd1 : 2'd0;
    pnew     = '0;
    res.way  = way_q;
    res.dead = 1'b0;
    res.rrpv = RrpvNear;
    if (acc_q.hit) begin
      if (prd_rdata_i[acc_q.sig] != CtrMax) begin
        prow_n[acc_q.sig] = prd_rdata_i[acc_q.sig] + 2'd1;
      end
      new_e.rrpv = RrpvNear;
      new_e.sig  = acc_q.sig;
      if (old_e.dead != CtrMax) begin
        new_e.dead = old_e.dead + 2'd1;
      end
    end else begin
      // The victim's counter weakens first; it may be the entry read below.
      if (prd_rdata_i[old_e.sig] != 2'd0) begin
        prow_n[old_e.sig] = prd_rdata_i[old_e.sig] - 2'd1;
      end
      pnew = prow_n[acc_q.sig];
      if (dead_dec == 2'd0) begin
        res.dead = 1'b1;
        res.rrpv = RrpvDistant;
      end else if (pnew[1]) begin
        res.rrpv = RrpvNear;
      end else if (pnew == 2'd1) begin
        res.rrpv = RrpvLong;
      end else begin
        res.rrpv = RrpvDistant;
      end
      new_e.rrpv = res.rrpv;
      new_e.sig  = acc_q.sig;
      new_e.dead = DeadInit;
    end
  end

  logic [SweepW-1:0] sw_m1;
  logic [CntW-1:0]   cnt_inc;

  always_comb begin
    state_d     = state_q;
    sw_d        = sw_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    row_d       = row_q;
    way_d       = way_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    res_o       = res;
    sw_m1       = sw_q - SweepW'(1);
    cnt_inc     = cnt_q + CntW'(1);
    blk_o       = '0;
    blk_o.raddr = acc_q.set;
    prd_o       = '0;
    prd_o.raddr = acc_q.set[PredRowW-1:0];
    status_o    = '0;

    case (state_q)
      ST_INIT: begin
        status_o.init = 1'b1;
        blk_o.we      = 1'b1;
        blk_o.waddr   = sw_q[SetW-1:0];
        blk_o.wdata   = row_reset();
        prd_o.we      = (sw_q[SweepW-1:PredRowW] == '0);
        prd_o.waddr   = sw_q[PredRowW-1:0];
        prd_o.wdata   = prow_reset();
        if (sw_q == SweepW'(NumSets - 1)) begin
          sw_d    = '0;
          state_d = ST_IDLE;
        end else begin
          sw_d = sw_q + SweepW'(1);
        end
      end
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        blk_o.raddr = in_data_i.set;
        prd_o.raddr = in_data_i.set[PredRowW-1:0];
        if (in_valid_i) begin
          acc_d = in_data_i;
          if (cnt_inc >= period_i) begin
            cnt_d   = '0;
            sw_d    = '0;
            state_d = ST_SWEEP;
          end else begin
            cnt_d   = cnt_inc;
            state_d = ST_DATA;
          end
        end
      end
      ST_SWEEP: begin
        // Read row k while writing back the decayed row k-1.
        status_o.sweep = 1'b1;
        blk_o.raddr    = sw_q[SetW-1:0];
        blk_o.we       = (sw_q != '0);
        blk_o.waddr    = sw_m1[SetW-1:0];
        blk_o.wdata    = row_decay(blk_rdata_i);
        if (sw_q == SweepW'(NumSets)) begin
          state_d = ST_READ;
        end else begin
          sw_d = sw_q + SweepW'(1);
        end
      end
      ST_READ: begin
        state_d = ST_DATA;
      end
      ST_DATA: begin
        if (acc_q.hit) begin
          row_d = blk_rdata_i;
          way_d = acc_q.way;
        end else begin
          row_d = aged;
          way_d = victim;
        end
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (res_ready_i) begin
          res_valid_o        = 1'b1;
          blk_o.we           = 1'b1;
          blk_o.waddr        = acc_q.set;
          blk_o.wdata        = row_q;
          blk_o.wdata[way_q] = new_e;
          prd_o.we           = 1'b1;
          prd_o.waddr        = acc_q.set[PredRowW-1:0];
          prd_o.wdata        = prow_n;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

endmodule

FILE: sv/ship_rrip_dead_block_replacement_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHiP-guided SRRIP replacement with dead-block counters
// Chooses the way for each cache access and keeps all per-block state in RAM.
// ----------------------------------------------------------------------------
// Each access runs the DATA and WRITE states and its result is registered in the
// output register; an access that completes a decay period first sweeps all 2048
// rows (SWEEP, READ). A new access is taken only once the read-modify-write of a
// set row (read, age and pick victim, write back) is done and WRITE has found a
// free output slot.
// Reset: an init pass over all 2048 sets fills the block and predictor RAMs; no input
// transfer is taken meanwhile, while configuration writes are always taken.
module ship_rrip_dead_block_replacement_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input tdata, from bit 0: set_index[10:0], pc[32:11], hit_way[36:33], zeros.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,
  // Input tuser: is_hit.
  input  logic        s_axis_tuser_i,
  // Output tdata, from bit 0: chosen_way[3:0], new_rrpv[5:4], predicted_dead[6], zero.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,
  // Configuration: number of accesses between global dead-counter decrements.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  import srdb_pkg::*;

  // The period register can be written at any time; it is only meant to be
  // changed while the block is idle.
  logic [CntW-1:0] period_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= DecayReset;
    end else if (cfg_valid_i) begin
      period_q <= cfg_data_i;
    end
  end

  // Unpack the input transfer; the PC is folded to its signature right away.
  access_t acc;
  always_comb begin
    acc.set = s_axis_tdata_i[10:0];
    acc.sig = make_sig(s_axis_tdata_i[32:11]);
    acc.hit = s_axis_tuser_i;
    acc.way = s_axis_tdata_i[36:33];
  end

  blk_port_t blk;
  prd_port_t prd;
  row_t      blk_rdata;
  prow_t     prd_rdata;
  status_t   status;
  result_t   res;
  logic      res_valid, res_ready;

  // Block state: one row per set, 16 ways of {signature, dead, rrpv}.
  srdb_ram #(
    .DataW (RowW),
    .Depth (NumSets)
  ) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (blk.we),
    .waddr_i (blk.waddr),
    .wdata_i (blk.wdata),
    .raddr_i (blk.raddr),
    .rdata_o (blk_rdata)
  );

  // Reuse predictor: row = low set bits, column = signature, so the victim's
  // counter and the incoming block's counter always share one row.
  srdb_ram #(
    .DataW (PredW),
    .Depth (PredRows)
  ) u_prd_ram (
    .clk_i   (clk_i),
    .we_i    (prd.we),
    .waddr_i (prd.waddr),
    .wdata_i (prd.wdata),
    .raddr_i (prd.raddr),
    .rdata_o (prd_rdata)
  );

  srdb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (acc),
    .period_i    (period_q),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .blk_o       (blk),
    .blk_rdata_i (blk_rdata),
    .prd_o       (prd),
    .prd_rdata_i (prd_rdata),
    .status_o    (status)
  );

  // Output register: a finished result waits here, so the sequencer can take
  // the next access while the consumer stalls.
  logic    out_valid_q;
  result_t out_q;

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q.dead, out_q.rrpv, out_q.way};

  // No access is taken while the RAMs are being initialized.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.init |-> !s_axis_tready_o)
    else $error("input taken during init pass");

  // No access is taken while the decay sweep runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.sweep |-> !s_axis_tready_o)
    else $error("input taken during decay sweep");

  // Only one access is in flight at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("second access taken before write-back");

  // A result is only produced into a free output slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (!out_valid_q || m_axis_tready_i))
    else $error("result overwrote a pending output");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replacement engine testbench
// Streams cache accesses into the SHiP/RRIP dead-block replacement engine,
// predicts each chosen way, insertion RRPV and dead flag, and checks them.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned Blocks    = 32768;
  localparam int unsigned PredSize  = 8192;
  localparam int unsigned CycleCap  = 3000000;
  localparam int unsigned HoldStart = 100;
  localparam int unsigned HoldLen   = 300;

  typedef struct {
    logic [10:0] set;
    logic [21:0] pc;
    logic        hit;
    logic [3:0]  way;
  } cache_access_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  ship_rrip_dead_block_replacement_top dut (.*);

  always #5 clk_i = ~clk_i;

  // Shadow copy of the engine state.
  logic [1:0]  rrpv_mem [Blocks];
  logic [1:0]  dead_mem [Blocks];
  logic [5:0]  sig_mem  [Blocks];
  logic [1:0]  reuse_mem [PredSize];
  logic [15:0] access_cnt;
  logic [15:0] decay_len;

  cache_access_t     access_q [$];
  srdb_pkg::result_t choice_q [$];
  int unsigned       errors = 0;
  int unsigned       taken = 0;
  bit                quiet = 1'b0;
  bit                in_fire = 1'b0;
  bit                hold_off = 1'b0;
  int unsigned       src_gap = 0;
  int unsigned       sink_gap = 0;

  function automatic srdb_pkg::result_t choose_way(cache_access_t a);
    srdb_pkg::result_t r;
    logic [5:0]  sig;
    logic [12:0] pidx;
    logic [12:0] vidx;
    logic [1:0]  maxr;
    logic [1:0]  ins;
    logic [3:0]  way;
    logic        dead;
    int unsigned base;
    int unsigned b;
    sig  = a.pc[5:0] ^ a.pc[13:8] ^ a.pc[21:16];
    pidx = {a.set[6:0], sig};
    base = a.set * 16;
    way  = a.way;
    dead = 1'b0;
    ins  = 2'd0;
    if (!a.hit) begin
      maxr = 2'd0;
      for (int w = 0; w < 16; w++)
        if (rrpv_mem[base + w] > maxr) maxr = rrpv_mem[base + w];
      for (int w = 0; w < 16; w++)
        rrpv_mem[base + w] = rrpv_mem[base + w] + (2'd3 - maxr);
      way = 4'd0;
      for (int w = 15; w >= 0; w--)
        if (rrpv_mem[base + w] == 2'd3) way = w[3:0];
    end
    access_cnt = access_cnt + 16'd1;
    if (access_cnt >= decay_len) begin
      access_cnt = '0;
      for (int i = 0; i < Blocks; i++)
        if (dead_mem[i] != 2'd0) dead_mem[i] = dead_mem[i] - 2'd1;
    end
    b = base + way;
    if (a.hit) begin
      rrpv_mem[b] = 2'd0;
      sig_mem[b]  = sig;
      if (reuse_mem[pidx] != 2'd3) reuse_mem[pidx] = reuse_mem[pidx] + 2'd1;
      if (dead_mem[b] != 2'd3) dead_mem[b] = dead_mem[b] + 2'd1;
    end else begin
      // The victim's counter is weakened before the new block's one is read.
      vidx = {a.set[6:0], sig_mem[b]};
      if (reuse_mem[vidx] != 2'd0) reuse_mem[vidx] = reuse_mem[vidx] - 2'd1;
      if (dead_mem[b] != 2'd0) dead_mem[b] = dead_mem[b] - 2'd1;
      if (dead_mem[b] == 2'd0) begin
        dead = 1'b1;
        ins  = 2'd3;
      end else if (reuse_mem[pidx] >= 2'd2) begin
        ins = 2'd0;
      end else if (reuse_mem[pidx] == 2'd1) begin
        ins = 2'd2;
      end else begin
        ins = 2'd3;
      end
      rrpv_mem[b] = ins;
      sig_mem[b]  = sig;
      dead_mem[b] = 2'd2;
    end
    r.way  = way;
    r.rrpv = ins;
    r.dead = dead;
    return r;
  endfunction

  // Sender: holds an item until its transfer, with random gaps between items.
  always @(negedge clk_i) begin
    logic          nvalid;
    cache_access_t a;
    nvalid = s_axis_tvalid_i && !in_fire;
    if (!nvalid) begin
      if (src_gap > 0) begin
        src_gap--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        src_gap = $urandom_range(1, 12);
      end else if (access_q.size() > 0) begin
        a = access_q.pop_front();
        s_axis_tdata_i <= {3'b000, a.way, a.pc, a.set};
        s_axis_tuser_i <= a.hit;
        nvalid = 1'b1;
      end
    end
    s_axis_tvalid_i <= nvalid;
  end

  // Input transfers: predict at the edge that accepts the item.
  always @(posedge clk_i) begin
    cache_access_t a;
    in_fire = s_axis_tvalid_i && s_axis_tready_o;
    if (in_fire) begin
      a.set = s_axis_tdata_i[10:0];
      a.pc  = s_axis_tdata_i[32:11];
      a.way = s_axis_tdata_i[36:33];
      a.hit = s_axis_tuser_i;
      choice_q.push_back(choose_way(a));
      taken++;
    end
  end

  // One long receiver hold-off so that the engine backs up into its input.
  always @(negedge clk_i) begin
    int unsigned left;
    if (taken == HoldStart && !hold_off && left == 0) begin
      hold_off = 1'b1;
      left = HoldLen;
    end else if (left > 0) begin
      left--;
      if (left == 0) hold_off = 1'b0;
    end
  end

  // Receiver stalls come in random bursts.
  always @(negedge clk_i) begin
    if (sink_gap > 0) begin
      sink_gap--;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      sink_gap = $urandom_range(1, 12);
    end
    m_axis_tready_i <= (sink_gap == 0) && !hold_off;
  end

  // Result checker.
  always @(posedge clk_i) begin
    srdb_pkg::result_t want;
    srdb_pkg::result_t got;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[6:0];
      if (choice_q.size() == 0) begin
        $error("result transfer with no access outstanding: %h", m_axis_tdata_o);
        errors++;
      end else begin
        want = choice_q.pop_front();
        if (got.way !== want.way) begin
          $error("chosen_way expected %0d actual %0d", want.way, got.way);
          errors++;
        end
        if (got.rrpv !== want.rrpv) begin
          $error("new_rrpv expected %0d actual %0d", want.rrpv, got.rrpv);
          errors++;
        end
        if (got.dead !== want.dead) begin
          $error("predicted_dead expected %0d actual %0d", want.dead, got.dead);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    int unsigned cycles;
    cycles++;
    if (cycles > CycleCap) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic add_access(logic [10:0] set, logic [21:0] pc, logic hit, logic [3:0] way);
    cache_access_t a;
    a.set = set;
    a.pc  = pc;
    a.hit = hit;
    a.way = way;
    access_q.push_back(a);
  endtask

  // Mostly a few hot sets and recurring PCs so that sets fill, age and reuse.
  task automatic add_random(int unsigned n);
    logic [10:0] set;
    logic [21:0] pc;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       set = 11'($urandom_range(0, 2047));
        1:       set = 11'h7FF - 11'($urandom_range(0, 1));
        default: set = 11'($urandom_range(0, 3) * 11'h81);
      endcase
      if ($urandom_range(0, 3) == 0) pc = 22'($urandom_range(0, 22'h3FFFFF));
      else pc = {8'($urandom_range(0, 7)), 14'h2A5C} ^ 22'h3C0000;
      add_access(set, pc, $urandom_range(0, 2) == 0, 4'($urandom_range(0, 15)));
    end
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (access_q.size() > 0 || s_axis_tvalid_i || choice_q.size() > 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_period(logic [15:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    decay_len = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    for (int i = 0; i < Blocks; i++) begin
      rrpv_mem[i] = 2'd3;
      dead_mem[i] = 2'd2;
      sig_mem[i]  = '0;
    end
    for (int i = 0; i < PredSize; i++) reuse_mem[i] = 2'd1;
    access_cnt = '0;
    decay_len  = 16'd4096;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes, a set filled by misses, hits and same-signature reuse.
    add_access(11'd0, 22'd0, 1'b0, 4'd0);
    add_access(11'h7FF, 22'h3FFFFF, 1'b0, 4'hF);
    add_access(11'h7FF, 22'h3FFFFF, 1'b1, 4'hF);
    add_access(11'd0, 22'd0, 1'b1, 4'd0);
    for (int i = 0; i < 17; i++) add_access(11'd5, 22'h15A5A5 + i, 1'b0, 4'hF);
    add_access(11'd5, 22'h000101, 1'b1, 4'd3);
    add_access(11'd5, 22'h000101, 1'b0, 4'd0);
    add_access(11'd5, 22'h000101, 1'b0, 4'd7);
    add_access(11'h400, 22'h2AAAAA, 1'b1, 4'hA);
    add_random(200);
    drain();

    // Decay on every access, then period 0 which behaves the same.
    write_period(16'd1);
    add_random(15);
    drain();
    write_period(16'd0);
    add_random(15);
    drain();
    write_period(16'hFFFF);
    add_random(200);
    drain();
    write_period(16'd3);
    add_random(120);
    drain();
    // Closing stretch runs without idling on either side.
    write_period(16'd7);
    quiet = 1'b1;
    add_random(160);
    drain();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
